### design/mbps_pkg.sv
// Shared types and codes for the masked byte pattern search block.
// Used by mbps_cell and masked_byte_pattern_search_top; depends on nothing.
`default_nettype none

package mbps_pkg;

   localparam int BYTE_W = 8;
   localparam int GROUP_W = 8;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_SCAN = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   typedef struct packed {
      logic scan;
      logic rotate;
      logic [BYTE_W-1:0] data;
      logic [BYTE_W-1:0] care;
   } cell_ctrl_type;

endpackage

`default_nettype wire

### design/mbps_cell.sv
// One cell of the search row: a window byte, a pattern byte and its mask.
// Uses mbps_pkg for the control struct; instantiated by the top level.
`default_nettype none

module mbps_cell (
   input  wire logic                          clock,
   input  wire mbps_pkg::cell_ctrl_type       ctrl,
   input  wire logic                          load_sel,
   input  wire logic                          active,
   input  wire logic [mbps_pkg::BYTE_W-1:0]   win_in,
   input  wire logic [mbps_pkg::BYTE_W-1:0]   pat_in,
   input  wire logic [mbps_pkg::BYTE_W-1:0]   msk_in,
   output      logic [mbps_pkg::BYTE_W-1:0]   win_out,
   output      logic [mbps_pkg::BYTE_W-1:0]   pat_out,
   output      logic [mbps_pkg::BYTE_W-1:0]   msk_out,
   output      logic                          eq_out
);

   logic [mbps_pkg::BYTE_W-1:0] win_ff;
   logic [mbps_pkg::BYTE_W-1:0] pat_ff;
   logic [mbps_pkg::BYTE_W-1:0] msk_ff;
   logic                        eq_ff;
   logic                        eq_in;

   assign eq_in = (((win_in ^ pat_ff) & msk_ff) == '0) || !active;

   always_ff @(posedge clock) begin
      if (ctrl.scan) begin
         win_ff <= win_in;
         eq_ff  <= eq_in;
      end
      if (ctrl.rotate) begin
         pat_ff <= pat_in;
         msk_ff <= msk_in;
      end else if (load_sel) begin
         pat_ff <= ctrl.data;
         msk_ff <= ctrl.care;
      end
   end

   assign win_out = win_ff;
   assign pat_out = pat_ff;
   assign msk_out = msk_ff;
   assign eq_out  = eq_ff;

endmodule

`default_nettype wire

### design/masked_byte_pattern_search_top.sv
// Masked byte pattern search: a row of mbps_cell instances, region tracking
// and a three-stage result pipeline. Depends on mbps_pkg and mbps_cell.
//
// Usage: words enter on the req_ channel (valid/stall) and carry an op code.
// A load word writes one pattern byte and its care mask, a restart word
// clears the current region, and a scan word shifts one stream byte into
// the window. Only scan words produce a result word on the rsp_ channel,
// in order. The csr_ port writes the pattern length.
// A scan word's result passes through the v1, v2 and v3 stages after it is
// accepted. One word is accepted per cycle while neither rsp_stall nor a
// realignment holds the input. Each cell registers its window byte compare
// in the accept cycle, eight-cell groups are reduced into group_ff, and
// the output register then takes the final match. After a length write the
// pattern row rotates one cell per cycle until aligned, holding req_stall high.
// When rsp_stall is high while a result waits, the whole pipeline holds and
// req_stall rises. Reset empties the pipeline, sets the length to one and
// starts a new region; pattern entries are undefined until loaded.
`default_nettype none

module masked_byte_pattern_search_top #(
   parameter int MAX_PATTERN = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [1:0]  req_op,
   input  wire logic [5:0]  req_entry_index,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [7:0]  req_care_mask,
   input  wire logic        req_last_byte,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic        rsp_match,
   output      logic [31:0] rsp_match_start,
   output      logic        rsp_region_done,
   output      logic        rsp_any_match,
   input  wire logic        csr_wr_en,
   input  wire logic [6:0]  csr_wr_data
);

   localparam int LW = $clog2(MAX_PATTERN + 1);
   localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int NG = (MAX_PATTERN + mbps_pkg::GROUP_W - 1) / mbps_pkg::GROUP_W;
   localparam int BW = mbps_pkg::BYTE_W;

   logic [6:0]    len_ff;
   logic [LW-1:0] eff_len;
   logic [LW-1:0] rot_ff;
   logic [LW-1:0] rot_in;
   logic          rotating;

   logic [31:0]   pos_ff;
   logic [31:0]   pos_in;
   logic [LW-1:0] seen_ff;
   logic [LW-1:0] seen_in;
   logic [LW-1:0] seen_next;
   logic          first_ff;
   logic          first_in;

   logic          advance;
   logic          accept;
   logic          do_scan;
   logic          do_load;
   logic          do_restart;
   logic          load_ok;
   logic [31:0]   load_pos;
   logic [IW-1:0] load_tgt;

   logic          v1_ff, v2_ff, v3_ff;
   logic [31:0]   start1_ff, start2_ff;
   logic          ok1_ff, ok2_ff;
   logic          last1_ff, last2_ff;
   logic          first1_ff, first2_ff;
   logic [NG-1:0] group_ff;
   logic          found_ff;
   logic          hit;
   logic          any;

   logic [NG*mbps_pkg::GROUP_W-1:0] eq_pad;
   logic [MAX_PATTERN-1:0]          eq_vec;
   logic [MAX_PATTERN-1:0]          active_vec;
   logic [MAX_PATTERN-1:0]          load_vec;
   logic [BW-1:0] win [MAX_PATTERN];
   logic [BW-1:0] pat [MAX_PATTERN];
   logic [BW-1:0] msk [MAX_PATTERN];

   mbps_pkg::cell_ctrl_type ctrl;

   logic          match_ff;
   logic [31:0]   match_start_ff;
   logic          done_ff;
   logic          any_ff;

   always_comb begin
      if (len_ff == '0) begin
         eff_len = LW'(1);
      end else if (32'(len_ff) > 32'(MAX_PATTERN)) begin
         eff_len = LW'(MAX_PATTERN);
      end else begin
         eff_len = LW'(len_ff);
      end
   end

   assign rotating  = (rot_ff != eff_len);
   assign rot_in    = (rot_ff == LW'(MAX_PATTERN)) ? LW'(1) : rot_ff + LW'(1);
   assign advance   = !(v3_ff && rsp_stall);
   assign req_stall = !advance || rotating;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      do_scan    = 1'b0;
      do_load    = 1'b0;
      do_restart = 1'b0;
      case (req_op)
         mbps_pkg::OP_LOAD:    do_load = accept;
         mbps_pkg::OP_SCAN:    do_scan = accept;
         mbps_pkg::OP_RESTART: do_restart = accept;
         default: ;
      endcase
   end

   // The cell at index k holds pattern entry (rot - 1 - k) modulo MAX_PATTERN.
   always_comb begin
      load_pos = 32'(rot_ff) - 32'd1 - 32'(req_entry_index);
      if (load_pos[31]) begin
         load_pos = load_pos + 32'(MAX_PATTERN);
      end
      load_tgt = load_pos[IW-1:0];
      load_ok  = do_load && (32'(req_entry_index) < 32'(MAX_PATTERN));
   end

   assign ctrl.scan   = do_scan;
   assign ctrl.rotate = rotating;
   assign ctrl.data   = req_data_byte;
   assign ctrl.care   = req_care_mask;

   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      assign active_vec[k] = (32'(k) < 32'(eff_len));
      assign load_vec[k]   = load_ok && (load_tgt == IW'(k));
      mbps_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .load_sel (load_vec[k]),
         .active   (active_vec[k]),
         .win_in   ((k == 0) ? req_data_byte : win[(k + MAX_PATTERN - 1) % MAX_PATTERN]),
         .pat_in   (pat[(k + MAX_PATTERN - 1) % MAX_PATTERN]),
         .msk_in   (msk[(k + MAX_PATTERN - 1) % MAX_PATTERN]),
         .win_out  (win[k]),
         .pat_out  (pat[k]),
         .msk_out  (msk[k]),
         .eq_out   (eq_vec[k])
      );
   end

   always_comb begin
      seen_next = (seen_ff == LW'(MAX_PATTERN)) ? seen_ff : seen_ff + LW'(1);
      pos_in    = pos_ff;
      seen_in   = seen_ff;
      first_in  = first_ff;
      if (do_restart || (do_scan && req_last_byte)) begin
         pos_in   = '0;
         seen_in  = '0;
         first_in = 1'b1;
      end else if (do_scan) begin
         pos_in   = (pos_ff == '1) ? pos_ff : pos_ff + 32'd1;
         seen_in  = seen_next;
         first_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= 7'd1;
         rot_ff   <= LW'(1);
         pos_ff   <= '0;
         seen_ff  <= '0;
         first_ff <= 1'b1;
      end else begin
         if (csr_wr_en) begin
            len_ff <= csr_wr_data;
         end
         if (rotating) begin
            rot_ff <= rot_in;
         end
         pos_ff   <= pos_in;
         seen_ff  <= seen_in;
         first_ff <= first_in;
      end
   end

   always_comb begin
      eq_pad = '1;
      eq_pad[MAX_PATTERN-1:0] = eq_vec;
   end

   assign hit = ok2_ff && (&group_ff);
   assign any = hit || (found_ff && !first2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         found_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= do_scan;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         if (v2_ff) begin
            found_ff <= any;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         start1_ff <= pos_ff - (32'(eff_len) - 32'd1);
         ok1_ff    <= (seen_next >= eff_len);
         last1_ff  <= req_last_byte;
         first1_ff <= first_ff;
         start2_ff <= start1_ff;
         ok2_ff    <= ok1_ff;
         last2_ff  <= last1_ff;
         first2_ff <= first1_ff;
         for (int g = 0; g < NG; g++) begin
            group_ff[g] <= &eq_pad[g*mbps_pkg::GROUP_W +: mbps_pkg::GROUP_W];
         end
         match_ff       <= hit;
         match_start_ff <= hit ? start2_ff : 32'd0;
         done_ff        <= last2_ff;
         any_ff         <= any;
      end
   end

   assign rsp_valid       = v3_ff;
   assign rsp_match       = match_ff;
   assign rsp_match_start = match_start_ff;
   assign rsp_region_done = done_ff;
   assign rsp_any_match   = any_ff;

   a_match_implies_any: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_match) |-> rsp_any_match)
      else $error("match reported without any_match");

   a_start_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_match) |-> (rsp_match_start == 32'd0))
      else $error("match_start nonzero on a result without a match");

   a_rotate_stalls: assert property (@(posedge clock) disable iff (reset)
      rotating |-> (req_stall && !do_scan && !load_ok))
      else $error("input taken while the pattern row is realigning");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire
